>>> rtl/lrl_pkg.sv
// lrl_pkg: shared types and constants for the LRU replacement list.
// Used by lrl_cell and lru_replacement_list; no dependencies.
package lrl_pkg;

    localparam int ENTRIES_DEF      = 16;
    localparam int PAGE_ID_BITS_DEF = 10;

    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_EVICT = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } lrl_state_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic look;     // compare the request page this cycle
        logic occupied; // cell lies below the fill count
        logic shift;    // take the neighbor's page this cycle
    } lrl_cell_ctrl_t;

endpackage

>>> rtl/lrl_cell.sv
// lrl_cell: one slot of the recency stack; holds a page id, flags a match
// and takes its more-recent neighbor's page on a shift. Depends on lrl_pkg.
module lrl_cell #(
    parameter int PAGE_ID_BITS = lrl_pkg::PAGE_ID_BITS_DEF
) (
    input  logic                       aclk,
    input  lrl_pkg::lrl_cell_ctrl_t    ctrl,
    input  logic [PAGE_ID_BITS-1:0]    req_page,
    input  logic [PAGE_ID_BITS-1:0]    prev_page,
    output logic [PAGE_ID_BITS-1:0]    page,
    output logic                       match
);
    import lrl_pkg::*;

    logic [PAGE_ID_BITS-1:0] page_reg;
    logic                    match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.look) begin
            match_reg <= ctrl.occupied && (page_reg == req_page);
        end
        if (ctrl.shift) begin
            page_reg <= prev_page;
        end
    end

    assign page  = page_reg;
    assign match = match_reg;

endmodule

>>> rtl/lru_replacement_list.sv
// lru_replacement_list: top level of the true-LRU replacement stack.
// Depends on lrl_pkg and lrl_cell.
//
// Usage:
//   Request channel s_*: s_op selects touch (move/insert s_page_id as most
//   recent) or evict (remove the least-recent page). Result channel m_*:
//   one result per request with m_status, m_victim_valid, m_victim_page.
//   The list is a row of ENTRIES cells; cell 0 holds the most recent page.
//   Each request passes through a compare state (S_LOOK), where every
//   cell compares its page to the request in parallel and registers a
//   match flag, and an update state (S_UPD), where on a touch that hits
//   or finds room the cells at or above the hit (or fill) point shift one
//   place toward the least-recent end and the result is loaded into the
//   output register. A new request is accepted in the update state as the
//   previous one commits.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result; cell contents are not cleared, only the fill count.
//   If the receiver stalls, the finished result waits in the output
//   register while one further request is accepted and looked up; its
//   update then holds until the output register frees.
module lru_replacement_list #(
    parameter int ENTRIES      = lrl_pkg::ENTRIES_DEF,
    parameter int PAGE_ID_BITS = lrl_pkg::PAGE_ID_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic [PAGE_ID_BITS-1:0] s_page_id,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic                    m_victim_valid,
    output logic [PAGE_ID_BITS-1:0] m_victim_page
);
    import lrl_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    // sequencer
    lrl_state_t state_reg, state_next;
    logic       out_free;
    logic       accept;
    logic       commit;

    // request registers
    logic                    req_op_reg;
    logic [PAGE_ID_BITS-1:0] req_page_reg;

    // fill count
    logic [CW-1:0] count_reg, count_next;

    // output register
    logic                    m_valid_reg;
    logic [1:0]              m_status_reg, m_status_next;
    logic                    m_victim_valid_reg, m_victim_valid_next;
    logic [PAGE_ID_BITS-1:0] m_victim_page_reg, m_victim_page_next;

    // cell row
    logic [PAGE_ID_BITS-1:0] cell_page [ENTRIES];
    logic [ENTRIES-1:0]      match_vec;
    logic [ENTRIES-1:0]      shift_hit;   // cell at or above the hit slot
    logic [ENTRIES-1:0]      shift_fill;  // cell at or above the insert slot
    logic [ENTRIES-1:0]      last_sel;    // one-hot: least-recent cell
    logic [PAGE_ID_BITS-1:0] victim_terms [ENTRIES];
    logic [PAGE_ID_BITS-1:0] victim_page;
    logic                    hit;
    logic                    do_shift_hit;
    logic                    do_shift_fill;

    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_UPD) && out_free;
    assign s_ready  = (state_reg == S_IDLE) || commit;
    assign accept   = s_valid && s_ready;
    assign hit      = |match_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_LOOK;
            end
            S_LOOK: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                if (commit) state_next = accept ? S_LOOK : S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_op_reg   <= s_op;
            req_page_reg <= s_page_id;
        end
    end

    // cells
    generate
        for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
            localparam logic [CW-1:0]      IDX  = CW'(k);
            localparam logic [CW-1:0]      IDX1 = CW'(k + 1);
            localparam logic [ENTRIES-1:0] GE_MASK =
                ~((ENTRIES'(1) << k) - ENTRIES'(1));

            lrl_cell_ctrl_t          ctrl;
            logic [PAGE_ID_BITS-1:0] prev_page;

            assign shift_hit[k]  = |(match_vec & GE_MASK);
            assign shift_fill[k] = (IDX <= count_reg);
            assign last_sel[k]   = (IDX1 == count_reg);

            assign ctrl.look     = (state_reg == S_LOOK);
            assign ctrl.occupied = (IDX < count_reg);
            assign ctrl.shift    = (do_shift_hit && shift_hit[k]) ||
                                   (do_shift_fill && shift_fill[k]);

            if (k == 0) begin : g_head
                assign prev_page = req_page_reg;
            end else begin : g_body
                assign prev_page = cell_page[k-1];
            end

            assign victim_terms[k] = cell_page[k] & {PAGE_ID_BITS{last_sel[k]}};

            lrl_cell #(
                .PAGE_ID_BITS (PAGE_ID_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .req_page  (req_page_reg),
                .prev_page (prev_page),
                .page      (cell_page[k]),
                .match     (match_vec[k])
            );
        end
    endgenerate

    always_comb begin
        victim_page = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            victim_page = victim_page | victim_terms[k];
        end
    end

    // update decision
    always_comb begin
        do_shift_hit        = 1'b0;
        do_shift_fill       = 1'b0;
        count_next          = count_reg;
        m_status_next       = STATUS_OK;
        m_victim_valid_next = 1'b0;
        m_victim_page_next  = '0;
        if (commit) begin
            if (req_op_reg == OP_TOUCH) begin
                if (hit) begin
                    do_shift_hit = 1'b1;
                end else if (count_reg < FULL_COUNT) begin
                    do_shift_fill = 1'b1;
                    count_next    = count_reg + CW'(1);
                end else begin
                    m_status_next = STATUS_FULL;
                end
            end else begin
                if (count_reg == '0) begin
                    m_status_next = STATUS_EMPTY;
                end else begin
                    count_next          = count_reg - CW'(1);
                    m_victim_valid_next = 1'b1;
                    m_victim_page_next  = victim_page;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_status_reg       <= m_status_next;
            m_victim_valid_reg <= m_victim_valid_next;
            m_victim_page_reg  <= m_victim_page_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_victim_valid = m_victim_valid_reg;
    assign m_victim_page  = m_victim_page_reg;

endmodule
